// ----- rtl/uvs_pkg.sv -----
// uvs_pkg: constants, opcodes and shared types for the unique value stack
// no dependencies; used by the interfaces, the stack cell and the top level

package uvs_pkg;

	// stack geometry and widths
	localparam int STACK_DEPTH = 64;
	localparam int DATA_W      = 32;
	localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
	localparam int KIND_W      = 2;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [COUNT_W-1:0]       count_t;
	typedef logic [KIND_W-1:0]        kind_t;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic  shift_down; // push: each cell takes the one above it
		logic  shift_up;   // pop: each cell takes the one below it
		data_t probe;      // value compared against every cell
	} cell_ctl_t;

endpackage

// ----- rtl/uvs_cmd_if.sv -----
// uvs_cmd_if: command channel of the unique value stack (valid, ready, payload)
// depends on uvs_pkg

interface uvs_cmd_if;
	logic            valid;
	logic            ready;
	uvs_pkg::kind_t  kind;
	uvs_pkg::data_t  push_value;

	modport source (output valid, output kind, output push_value, input ready);
	modport sink   (input valid, input kind, input push_value, output ready);
endinterface

// ----- rtl/uvs_rsp_if.sv -----
// uvs_rsp_if: result channel of the unique value stack (valid, ready, payload)
// depends on uvs_pkg

interface uvs_rsp_if;
	logic            valid;
	logic            ready;
	logic            pop_error;
	logic            push_duplicate;
	logic            push_full;
	logic            top_valid;
	uvs_pkg::data_t  top_value;
	uvs_pkg::count_t entry_count;

	modport source (output valid, output pop_error, output push_duplicate,
		output push_full, output top_valid, output top_value, output entry_count,
		input ready);
	modport sink   (input valid, input pop_error, input push_duplicate,
		input push_full, input top_valid, input top_value, input entry_count,
		output ready);
endinterface

// ----- rtl/uvs_cell.sv -----
// uvs_cell: one entry of the stack chain; shifts with its neighbors and
// compares its value against the probe. depends on uvs_pkg

module uvs_cell (
	input  logic               clk,
	input  uvs_pkg::cell_ctl_t ctl,
	input  logic               occupied,
	input  uvs_pkg::data_t     from_above,
	input  uvs_pkg::data_t     from_below,
	output uvs_pkg::data_t     value,
	output logic               hit
);

	uvs_pkg::data_t value_q;

	// entry register, moves down on push and up on pop
	always_ff @(posedge clk) begin
		if (ctl.shift_down) begin
			value_q <= from_above;
		end else if (ctl.shift_up) begin
			value_q <= from_below;
		end
	end

	// match only counts for live entries
	assign hit   = occupied && (value_q == ctl.probe);
	assign value = value_q;

endmodule

// ----- rtl/unique_value_stack.sv -----
// unique_value_stack: LIFO of distinct 32-bit values built as a chain of cells
// result: registered, and valid in the cycle after the command item is accepted
// throughput: one item per cycle while the result is taken (rsp.ready); the duplicate check compares all cells at once
// reset: entry count and result valid clear asynchronously; cell contents
// are not reset and are never read before written
// depends on uvs_pkg, uvs_cmd_if, uvs_rsp_if, uvs_cell

module unique_value_stack (
	input  logic          clk,
	input  logic          arst_n,
	uvs_cmd_if.sink       cmd,
	uvs_rsp_if.source     rsp
);

	localparam int DEPTH = uvs_pkg::STACK_DEPTH;

	uvs_pkg::count_t    count_q;
	uvs_pkg::count_t    count_d;
	uvs_pkg::cell_ctl_t ctl;
	uvs_pkg::data_t     cell_value [DEPTH];
	logic [DEPTH-1:0]   cell_hit;
	logic               accept;
	logic               dup;
	logic               full;
	logic               empty;
	logic               pop_err_d;
	logic               dup_d;
	logic               full_d;
	uvs_pkg::data_t     top_d;

	logic               rsp_valid_q;
	logic               pop_error_q;
	logic               push_duplicate_q;
	logic               push_full_q;
	logic               top_valid_q;
	uvs_pkg::data_t     top_value_q;
	uvs_pkg::count_t    entry_count_q;

	// output register frees up when taken
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;

	assign dup   = |cell_hit;
	assign full  = (count_q == uvs_pkg::count_t'(DEPTH));
	assign empty = (count_q == '0);

	// decode the operation
	always_comb begin
		ctl.shift_down = 1'b0;
		ctl.shift_up   = 1'b0;
		ctl.probe      = cmd.push_value;
		pop_err_d      = 1'b0;
		dup_d          = 1'b0;
		full_d         = 1'b0;
		count_d        = count_q;
		case (cmd.kind)
			uvs_pkg::KIND_PUSH: begin
				if (dup) begin
					dup_d = 1'b1;
				end else if (full) begin
					full_d = 1'b1;
				end else begin
					ctl.shift_down = accept;
					count_d        = count_q + 1'b1;
				end
			end
			uvs_pkg::KIND_POP: begin
				if (empty) begin
					pop_err_d = 1'b1;
				end else begin
					ctl.shift_up = accept;
					count_d      = count_q - 1'b1;
				end
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	// chain of cells, cell 0 is the top of stack
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		uvs_pkg::data_t above;
		uvs_pkg::data_t below;
		if (i == 0) begin : g_top
			assign above = cmd.push_value;
		end else begin : g_mid
			assign above = cell_value[i-1];
		end
		if (i == DEPTH - 1) begin : g_bot
			assign below = '0;
		end else begin : g_up
			assign below = cell_value[i+1];
		end
		uvs_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (count_q > uvs_pkg::count_t'(i)),
			.from_above (above),
			.from_below (below),
			.value      (cell_value[i]),
			.hit        (cell_hit[i])
		);
	end

	// top of stack after the step
	always_comb begin
		if (count_d == '0) begin
			top_d = '0;
		end else if (ctl.shift_down) begin
			top_d = cmd.push_value;
		end else if (ctl.shift_up) begin
			top_d = (DEPTH > 1) ? cell_value[(DEPTH > 1) ? 1 : 0] : '0;
		end else begin
			top_d = cell_value[0];
		end
	end

	// entry count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pop_error_q      <= pop_err_d;
			push_duplicate_q <= dup_d;
			push_full_q      <= full_d;
			top_valid_q      <= (count_d != '0);
			top_value_q      <= top_d;
			entry_count_q    <= count_d;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.pop_error      = pop_error_q;
	assign rsp.push_duplicate = push_duplicate_q;
	assign rsp.push_full      = push_full_q;
	assign rsp.top_valid      = top_valid_q;
	assign rsp.top_value      = top_value_q;
	assign rsp.entry_count    = entry_count_q;

endmodule
